[src/rqi_pkg.sv]
// Shared types, constants and fixed-point helpers for the ray/quad intersection block.
package rqi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int WIDE_W      = PROD_W - FRAC_BITS;
  localparam int DIST_W      = COORD_WIDTH - 1;
  localparam int DIV_SHIFT   = COORD_WIDTH - 1 - FRAC_BITS;
  localparam int TRI_LAT     = 6;
  localparam int DIV_LAT     = COORD_WIDTH;
  localparam int RAY_LAT     = TRI_LAT + DIV_LAT;
  localparam int CFG_AW      = 6;
  localparam int NUM_PACKED  = 6;

  localparam logic [2:0] REG_EPSILON  = 3'd6;
  localparam logic [2:0] REG_MIN_DIST = 3'd7;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef coord_t [2:0] vec_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        distance;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } result_t;

  // clamp a wide signed value to the coordinate range
  function automatic coord_t sat_wide(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(signed'({1'b0, {(COORD_WIDTH-1){1'b1}}}));
    lo = -hi - WIDE_W'(1);
    if (v > hi) return coord_t'(hi);
    if (v < lo) return coord_t'(lo);
    return coord_t'(v);
  endfunction

  // product, floor shift by the fraction bits, saturate
  function automatic coord_t mulq(input coord_t a, input coord_t b);
    logic signed [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b);
    return sat_wide(p[PROD_W-1:FRAC_BITS]);
  endfunction

  function automatic coord_t sat_sub(input coord_t a, input coord_t b);
    logic signed [WIDE_W-1:0] d;
    d = WIDE_W'(a) - WIDE_W'(b);
    return sat_wide(d);
  endfunction

  function automatic coord_t sat_add3(input coord_t a, input coord_t b, input coord_t c);
    logic signed [WIDE_W-1:0] s;
    s = WIDE_W'(a) + WIDE_W'(b) + WIDE_W'(c);
    return sat_wide(s);
  endfunction

endpackage

[src/rqi_tri.sv]
// Triangle front end: edges, cross and dot products, sign fold and bounds tests.
module rqi_tri import rqi_pkg::*; (
  input  logic        clk,
  input  ray_t        ray,
  input  vec_t        c0,
  input  vec_t        c1,
  input  vec_t        c2,
  input  logic [15:0] epsilon,
  output logic        ok,
  output logic [COORD_WIDTH-1:0] tn,
  output logic [COORD_WIDTH-1:0] det
);

  vec_t e1_0, e2_0, s_0, d_0;
  vec_t e1_1, e2_1, s_1, d_1;
  coord_t [5:0] hp_1, qp_1;
  vec_t e1_2, e2_2, s_2, d_2, h_2, q_2;
  coord_t [2:0] detp_3, unp_3, vnp_3, tnp_3;
  coord_t det_4, un_4, vn_4, tn_4;

  logic signed [COORD_WIDTH:0]   detn, unn, vnn, tnn;
  logic signed [COORD_WIDTH+1:0] uv;
  logic                          neg;
  vec_t org, dir;

  assign org = {ray.origin_z, ray.origin_y, ray.origin_x};
  assign dir = {ray.dir_z, ray.dir_y, ray.dir_x};

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e1_0[k] <= sat_sub(c1[k], c0[k]);
      e2_0[k] <= sat_sub(c2[k], c0[k]);
      s_0[k]  <= sat_sub(org[k], c0[k]);
    end
    d_0 <= dir;

    hp_1[0] <= mulq(d_0[1], e2_0[2]);
    hp_1[1] <= mulq(d_0[2], e2_0[1]);
    hp_1[2] <= mulq(d_0[2], e2_0[0]);
    hp_1[3] <= mulq(d_0[0], e2_0[2]);
    hp_1[4] <= mulq(d_0[0], e2_0[1]);
    hp_1[5] <= mulq(d_0[1], e2_0[0]);
    qp_1[0] <= mulq(s_0[1], e1_0[2]);
    qp_1[1] <= mulq(s_0[2], e1_0[1]);
    qp_1[2] <= mulq(s_0[2], e1_0[0]);
    qp_1[3] <= mulq(s_0[0], e1_0[2]);
    qp_1[4] <= mulq(s_0[0], e1_0[1]);
    qp_1[5] <= mulq(s_0[1], e1_0[0]);
    e1_1 <= e1_0;
    e2_1 <= e2_0;
    s_1  <= s_0;
    d_1  <= d_0;

    for (int k = 0; k < 3; k++) begin
      h_2[k] <= sat_sub(hp_1[2*k], hp_1[2*k+1]);
      q_2[k] <= sat_sub(qp_1[2*k], qp_1[2*k+1]);
    end
    e1_2 <= e1_1;
    e2_2 <= e2_1;
    s_2  <= s_1;
    d_2  <= d_1;

    for (int k = 0; k < 3; k++) begin
      detp_3[k] <= mulq(e1_2[k], h_2[k]);
      unp_3[k]  <= mulq(s_2[k], h_2[k]);
      vnp_3[k]  <= mulq(d_2[k], q_2[k]);
      tnp_3[k]  <= mulq(e2_2[k], q_2[k]);
    end

    det_4 <= sat_add3(detp_3[0], detp_3[1], detp_3[2]);
    un_4  <= sat_add3(unp_3[0], unp_3[1], unp_3[2]);
    vn_4  <= sat_add3(vnp_3[0], vnp_3[1], vnp_3[2]);
    tn_4  <= sat_add3(tnp_3[0], tnp_3[1], tnp_3[2]);

    ok  <= (detn[COORD_WIDTH-1:0] >= COORD_WIDTH'(epsilon)) && (det_4 != '0) &&
           !unn[COORD_WIDTH] && (unn <= detn) && !vnn[COORD_WIDTH] &&
           (uv <= (COORD_WIDTH+2)'(detn)) && !tnn[COORD_WIDTH] && (tnn != '0);
    tn  <= tnn[COORD_WIDTH-1:0];
    det <= detn[COORD_WIDTH-1:0];
  end

  // fold the sign of the determinant into all four terms
  always_comb begin
    neg  = det_4[COORD_WIDTH-1];
    detn = neg ? -(COORD_WIDTH+1)'(det_4) : (COORD_WIDTH+1)'(det_4);
    unn  = neg ? -(COORD_WIDTH+1)'(un_4)  : (COORD_WIDTH+1)'(un_4);
    vnn  = neg ? -(COORD_WIDTH+1)'(vn_4)  : (COORD_WIDTH+1)'(vn_4);
    tnn  = neg ? -(COORD_WIDTH+1)'(tn_4)  : (COORD_WIDTH+1)'(tn_4);
    uv   = (COORD_WIDTH+2)'(unn) + (COORD_WIDTH+2)'(vnn);
  end

endmodule

[src/rqi_div.sv]
// Pipelined restoring divider: t = (tn << FRAC_BITS) / det, one quotient bit per stage.
module rqi_div import rqi_pkg::*; (
  input  logic                   clk,
  input  logic [COORD_WIDTH-1:0] tn,
  input  logic [COORD_WIDTH-1:0] det,
  output logic [DIST_W-1:0]      t
);

  localparam int STEPS = DIST_W;

  logic [COORD_WIDTH-1:0] rem [0:STEPS];
  logic [COORD_WIDTH-1:0] dv  [0:STEPS];
  logic [DIV_SHIFT-1:0]   num [0:STEPS];
  logic [DIST_W-1:0]      quo [0:STEPS];
  logic                   sat [0:STEPS];

  logic [COORD_WIDTH+DIV_SHIFT-1:0] lhs, rhs;

  assign lhs = {{DIV_SHIFT{1'b0}}, tn};
  assign rhs = {det, {DIV_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    // whole part beyond range saturates the distance
    sat[0] <= lhs >= rhs;
    rem[0] <= COORD_WIDTH'(tn >> DIV_SHIFT);
    num[0] <= tn[DIV_SHIFT-1:0];
    dv[0]  <= det;
    quo[0] <= '0;
    for (int k = 0; k < STEPS; k++) begin : step
      logic [COORD_WIDTH:0] trial;
      trial = {rem[k], num[k][DIV_SHIFT-1]};
      if (trial >= {1'b0, dv[k]}) begin
        rem[k+1] <= COORD_WIDTH'(trial - {1'b0, dv[k]});
        quo[k+1] <= {quo[k][DIST_W-2:0], 1'b1};
      end else begin
        rem[k+1] <= trial[COORD_WIDTH-1:0];
        quo[k+1] <= {quo[k][DIST_W-2:0], 1'b0};
      end
      num[k+1] <= {num[k][DIV_SHIFT-2:0], 1'b0};
      dv[k+1]  <= dv[k];
      sat[k+1] <= sat[k];
    end
  end

  assign t = sat[STEPS] ? {DIST_W{1'b1}} : quo[STEPS];

endmodule

[src/rqi_point.sv]
// Hit selection between the two triangles and hit point computation.
module rqi_point import rqi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  ray_t              ray,
  input  logic              ok_a,
  input  logic              ok_b,
  input  logic [DIST_W-1:0] t_a,
  input  logic [DIST_W-1:0] t_b,
  input  logic [15:0]       min_distance,
  output logic              done,
  output result_t           result
);

  logic              v0, v1;
  logic              hit0, hit1;
  logic [DIST_W-1:0] t0, t1;
  vec_t              org0, dir0, org1, prod1;
  logic              hit_a, hit_b;

  assign hit_a = ok_a && (t_a > DIST_W'(min_distance));
  assign hit_b = ok_b && (t_b > DIST_W'(min_distance));

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= valid;
      v1   <= v0;
      done <= v1;
    end
    // triangle A wins when both are hit
    hit0 <= hit_a || hit_b;
    t0   <= hit_a ? t_a : t_b;
    org0 <= {ray.origin_z, ray.origin_y, ray.origin_x};
    dir0 <= {ray.dir_z, ray.dir_y, ray.dir_x};

    for (int k = 0; k < 3; k++) begin
      prod1[k] <= mulq(dir0[k], coord_t'({1'b0, t0}));
    end
    hit1 <= hit0;
    t1   <= t0;
    org1 <= org0;

    result.hit      <= hit1;
    result.distance <= hit1 ? t1 : '0;
    result.point_x  <= hit1 ? sat_add3(org1[0], prod1[0], '0) : '0;
    result.point_y  <= hit1 ? sat_add3(org1[1], prod1[1], '0) : '0;
    result.point_z  <= hit1 ? sat_add3(org1[2], prod1[2], '0) : '0;
  end

endmodule

[src/ray_quad_intersection.sv]
// Top level: configuration registers, ray delay line and the two triangle lanes.
//
// Usage: raise start with a ray on the ray port; it is taken at any edge where
// busy is low, and busy never rises, so a ray can be issued every cycle.
// The result appears on the result port for one cycle with done high, after
// the edge, cross and dot product stages with the sign fold and bounds test,
// the divider stages (one quotient bit per stage, plus the saturation check),
// and the selection, hit point product and sum registers.
// Throughput is one ray per cycle; both triangles are tested in parallel lanes.
// The receiver cannot hold results off and there is no backpressure.
// Corners, epsilon and minimum distance are written over the APB port at byte
// address 8*i; change them only while no ray is in flight.
// Reset clears the valid bits of the pipeline and sets the registers to their
// reset values (corners zero, epsilon and minimum distance one).
module ray_quad_intersection import rqi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ray_t              ray,
  output logic              done,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  logic [63:0] packed_reg [0:NUM_PACKED-1];
  logic [15:0] epsilon;
  logic [15:0] min_distance;
  logic [2:0]  index;
  logic        wr;

  logic valid_dly [0:RAY_LAT-1];
  ray_t ray_dly   [0:RAY_LAT-1];
  logic ok_a_dly  [0:DIV_LAT-1];
  logic ok_b_dly  [0:DIV_LAT-1];

  vec_t c0, c1, c2, c3;
  logic ok_a, ok_b;
  logic [COORD_WIDTH-1:0] tn_a, det_a, tn_b, det_b;
  logic [DIST_W-1:0] t_a, t_b;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign index  = paddr[5:3];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_PACKED; k++) packed_reg[k] <= '0;
      epsilon      <= 16'd1;
      min_distance <= 16'd1;
    end else if (wr) begin
      case (index)
        REG_EPSILON:  epsilon      <= pwdata[15:0];
        REG_MIN_DIST: min_distance <= pwdata[15:0];
        default:      packed_reg[index] <= pwdata;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_EPSILON:  prdata = {48'd0, epsilon};
      REG_MIN_DIST: prdata = {48'd0, min_distance};
      default:      prdata = packed_reg[index];
    endcase
  end

  assign c0 = {packed_reg[1][31:0],  packed_reg[0][63:32], packed_reg[0][31:0]};
  assign c1 = {packed_reg[2][63:32], packed_reg[2][31:0],  packed_reg[1][63:32]};
  assign c2 = {packed_reg[4][31:0],  packed_reg[3][63:32], packed_reg[3][31:0]};
  assign c3 = {packed_reg[5][63:32], packed_reg[5][31:0],  packed_reg[4][63:32]};

  // carry the ray and its valid bit alongside the arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RAY_LAT; k++) valid_dly[k] <= 1'b0;
    end else begin
      valid_dly[0] <= start && !busy;
      for (int k = 1; k < RAY_LAT; k++) valid_dly[k] <= valid_dly[k-1];
    end
    ray_dly[0]  <= ray;
    ok_a_dly[0] <= ok_a;
    ok_b_dly[0] <= ok_b;
    for (int k = 1; k < RAY_LAT; k++) ray_dly[k] <= ray_dly[k-1];
    for (int k = 1; k < DIV_LAT; k++) begin
      ok_a_dly[k] <= ok_a_dly[k-1];
      ok_b_dly[k] <= ok_b_dly[k-1];
    end
  end

  rqi_tri u_tri_a (
    .clk(clk), .ray(ray), .c0(c0), .c1(c1), .c2(c2), .epsilon(epsilon),
    .ok(ok_a), .tn(tn_a), .det(det_a)
  );

  rqi_tri u_tri_b (
    .clk(clk), .ray(ray), .c0(c0), .c1(c2), .c2(c3), .epsilon(epsilon),
    .ok(ok_b), .tn(tn_b), .det(det_b)
  );

  rqi_div u_div_a (.clk(clk), .tn(tn_a), .det(det_a), .t(t_a));
  rqi_div u_div_b (.clk(clk), .tn(tn_b), .det(det_b), .t(t_b));

  rqi_point u_point (
    .clk(clk), .rst(rst), .valid(valid_dly[RAY_LAT-1]), .ray(ray_dly[RAY_LAT-1]),
    .ok_a(ok_a_dly[DIV_LAT-1]), .ok_b(ok_b_dly[DIV_LAT-1]), .t_a(t_a), .t_b(t_b),
    .min_distance(min_distance), .done(done), .result(result)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, RAY_LAT + 3))
    else $error("result without a ray taken at the expected latency");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> result.distance == '0 && result.point_x == '0 &&
                            result.point_y == '0 && result.point_z == '0)
    else $error("miss carries nonzero fields");

  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    done && result.hit |-> result.distance != '0)
    else $error("hit with zero distance");

endmodule
